// ===== sv/wscm_pkg.sv =====
// package for the windowed sigma current meter
// constants, config indexes, controller states and command/status structs; no dependencies
package wscm_pkg;

    localparam int BUFFER_DEPTH = 256;
    localparam int ADC_BITS = 10;
    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 2);
    // sum of up to BUFFER_DEPTH samples, with room for the later Q8 shift
    localparam int SUM_W = ADC_BITS + ADDR_W + 1 + 8;
    // sum of squared Q8 deviations
    localparam int SQ_W = 2 * (ADC_BITS + 8) + ADDR_W + 1;
    localparam int SIG_W = (SQ_W + 1) / 2;
    localparam int TOTAL_W = 24;

    localparam logic [2:0] CFG_WARMUP = 3'd0;
    localparam logic [2:0] CFG_TICKS = 3'd1;
    localparam logic [2:0] CFG_EXPECTED = 3'd2;
    localparam logic [2:0] CFG_SLOPE = 3'd3;
    localparam logic [2:0] CFG_INTERCEPT = 3'd4;
    localparam logic [2:0] CFG_THRESHOLD = 3'd5;
    localparam logic [2:0] CFG_VOLTS = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MEAN,
        ST_SQ,
        ST_VAR,
        ST_SQRT,
        ST_ACC,
        ST_REPORT,
        ST_CUR,
        ST_POW,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic store;      // write sample
        logic warm_tick;  // warm-up tick
        logic clr_win;
        logic sum_start;
        logic sum_step;
        logic div_start;  // start shared divider
        logic div_sel;    // 0 mean, 1 variance; report uses div_rep
        logic div_rep;
        logic sq_start;
        logic sq_step;
        logic sqrt_start;
        logic acc;
        logic tick_cnt;
        logic cur;
        logic pow;
        logic out_load;
        logic clr_tot;
    } cmd_t;

    typedef struct packed {
        logic warm;
        logic valid;
        logic walk_done;
        logic div_done;
        logic sqrt_done;
        logic report;
        logic out_busy;
    } stat_t;

endpackage

// ===== sv/wscm_datapath.sv =====
// datapath of the windowed sigma current meter: sample memory, accumulators,
// shared restoring divider, bit-serial square root, report math; uses wscm_pkg
module wscm_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wscm_pkg::cmd_t               cmd,
    output wscm_pkg::stat_t              stat,
    input  logic [wscm_pkg::ADC_BITS-1:0] sample,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_idx,
    input  logic [31:0]                  cfg_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [26:0]                  current_ua,
    output logic [35:0]                  power_uw,
    output logic                         above_threshold,
    output logic [5:0]                   windows_used
);
    localparam int AW = wscm_pkg::ADDR_W;
    localparam int CW = wscm_pkg::CNT_W;
    localparam int DW = wscm_pkg::SQ_W;
    localparam int QW = wscm_pkg::SQ_W;
    localparam int DCW = $clog2(DW + 1);
    localparam int SW = wscm_pkg::SIG_W;
    localparam int SCW = $clog2(SW + 1);
    localparam int MW = wscm_pkg::ADC_BITS + 9;

    logic [2:0]  warmup_reg;
    logic [5:0]  ticks_reg;
    logic [7:0]  expected_reg;
    logic [16:0] slope_reg;
    logic signed [20:0] intercept_reg;
    logic [19:0] thresh_reg;
    logic [8:0]  volts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warmup_reg <= 3'd5;
            ticks_reg <= 6'd60;
            expected_reg <= 8'd250;
            slope_reg <= 17'd66000;
            intercept_reg <= -21'sd7000;
            thresh_reg <= 20'd36000;
            volts_reg <= 9'd230;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                wscm_pkg::CFG_WARMUP:    warmup_reg <= cfg_data[2:0];
                wscm_pkg::CFG_TICKS:     ticks_reg <= cfg_data[5:0];
                wscm_pkg::CFG_EXPECTED:  expected_reg <= cfg_data[7:0];
                wscm_pkg::CFG_SLOPE:     slope_reg <= cfg_data[16:0];
                wscm_pkg::CFG_INTERCEPT: intercept_reg <= cfg_data[20:0];
                wscm_pkg::CFG_THRESHOLD: thresh_reg <= cfg_data[19:0];
                wscm_pkg::CFG_VOLTS:     volts_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // sample memory
    logic [wscm_pkg::ADC_BITS-1:0] mem [wscm_pkg::BUFFER_DEPTH];
    logic [wscm_pkg::ADC_BITS-1:0] rd_reg;
    logic [CW-1:0] win_reg;
    logic [CW-1:0] ptr_reg;
    logic          rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.store && win_reg < CW'(wscm_pkg::BUFFER_DEPTH))
            mem[win_reg[AW-1:0]] <= sample;
        rd_reg <= mem[ptr_reg[AW-1:0]];
    end

    logic [2:0] warm_cnt_reg;
    logic [5:0] tick_reg;
    logic [5:0] vw_reg;
    logic [wscm_pkg::TOTAL_W-1:0] total_reg;
    logic [wscm_pkg::SUM_W-1:0] sum_reg;
    logic [DW-1:0] sq_reg;
    logic [MW-1:0] mean_reg;
    logic [SW-1:0] sig_reg;

    // divider
    logic [DW-1:0] dq_reg;
    logic [DW-1:0] drem_reg;
    logic [DW-1:0] dden_reg;
    logic [DCW-1:0] dcnt_reg;
    logic          dbusy_reg;
    logic [DW:0]   dtrial;

    // sqrt
    logic [QW-1:0] qv_reg;
    logic [QW-1:0] qres_reg;
    logic [QW-1:0] qbit_reg;
    logic [SCW-1:0] qcnt_reg;
    logic          qbusy_reg;

    logic signed [27:0] cur_reg;
    logic signed [41:0] prod_reg;
    logic          out_valid_reg;
    logic [26:0]   o_cur_reg;
    logic [35:0]   o_pow_reg;
    logic          o_abv_reg;
    logic [5:0]    o_vw_reg;

    logic signed [wscm_pkg::ADC_BITS+9:0] dev;
    logic [2*(wscm_pkg::ADC_BITS+9)-1:0] dev_sq;
    logic signed [28:0] cur_sum;

    assign dev = $signed({2'b00, rd_reg, 8'd0}) - $signed({1'b0, mean_reg});
    assign dev_sq = (2*(wscm_pkg::ADC_BITS+9))'(dev * dev);
    assign dtrial = {drem_reg[DW-1:0], dq_reg[DW-1]} - {1'b0, dden_reg};
    assign cur_sum = 29'(signed'({1'b0, prod_reg[41:8]})) + 29'(intercept_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
            warm_cnt_reg <= '0;
            tick_reg <= '0;
            vw_reg <= '0;
            total_reg <= '0;
            dbusy_reg <= 1'b0;
            qbusy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            ptr_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.store)
                win_reg <= (win_reg < CW'(wscm_pkg::BUFFER_DEPTH)) ? win_reg + 1'b1
                         : CW'(wscm_pkg::BUFFER_DEPTH + 1);
            if (cmd.warm_tick)
                warm_cnt_reg <= warm_cnt_reg + 1'b1;
            if (cmd.clr_win)
                win_reg <= '0;
            if (cmd.tick_cnt && tick_reg != 6'd63)
                tick_reg <= tick_reg + 1'b1;
            if (cmd.acc)
            begin
                total_reg <= ({1'b0, total_reg} + (wscm_pkg::TOTAL_W+1)'(sig_reg)
                             > {1'b0, {wscm_pkg::TOTAL_W{1'b1}}})
                             ? '1 : total_reg + wscm_pkg::TOTAL_W'(sig_reg);
                if (vw_reg != 6'd63)
                    vw_reg <= vw_reg + 1'b1;
            end
            if (cmd.clr_tot)
            begin
                tick_reg <= '0;
                total_reg <= '0;
                vw_reg <= '0;
            end
            // memory walk, read data follows the pointer in the next cycle
            if (cmd.sum_start || cmd.sq_start)
            begin
                ptr_reg <= '0;
                rd_ok_reg <= 1'b0;
            end
            else if (cmd.sum_step || cmd.sq_step)
            begin
                rd_ok_reg <= ptr_reg < win_reg;
                if (ptr_reg < win_reg)
                    ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.div_start)
                dbusy_reg <= 1'b1;
            else if (dbusy_reg && dcnt_reg == DCW'(1))
                dbusy_reg <= 1'b0;
            if (cmd.sqrt_start)
                qbusy_reg <= 1'b1;
            else if (qbusy_reg && qcnt_reg == SCW'(1))
                qbusy_reg <= 1'b0;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_start)
            sum_reg <= '0;
        else if (cmd.sum_step && rd_ok_reg)
            sum_reg <= sum_reg + wscm_pkg::SUM_W'(rd_reg);
        if (cmd.sq_start)
            sq_reg <= '0;
        else if (cmd.sq_step && rd_ok_reg)
            sq_reg <= sq_reg + DW'(dev_sq);
        if (cmd.div_start)
        begin
            if (cmd.div_rep)
            begin
                dq_reg <= DW'(total_reg) + DW'(vw_reg[5:1]);
                dden_reg <= DW'(vw_reg);
            end
            else if (!cmd.div_sel)
            begin
                dq_reg <= DW'({sum_reg[wscm_pkg::SUM_W-9:0], 8'd0}) + DW'(win_reg[CW-1:1]);
                dden_reg <= DW'(win_reg);
            end
            else
            begin
                dq_reg <= sq_reg;
                dden_reg <= DW'(win_reg);
            end
            drem_reg <= '0;
            dcnt_reg <= DCW'(DW);
        end
        else if (dbusy_reg)
        begin
            if (!dtrial[DW])
                drem_reg <= dtrial[DW-1:0];
            else
                drem_reg <= {drem_reg[DW-2:0], dq_reg[DW-1]};
            dq_reg <= {dq_reg[DW-2:0], ~dtrial[DW]};
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.sqrt_start)
        begin
            qv_reg <= dq_reg;
            qres_reg <= '0;
            qbit_reg <= QW'(1) << (2 * (SW - 1));
            qcnt_reg <= SCW'(SW);
        end
        else if (qbusy_reg)
        begin
            if (qv_reg >= qres_reg + qbit_reg)
            begin
                qv_reg <= qv_reg - (qres_reg + qbit_reg);
                qres_reg <= (qres_reg >> 1) + qbit_reg;
            end
            else
                qres_reg <= qres_reg >> 1;
            qbit_reg <= qbit_reg >> 2;
            qcnt_reg <= qcnt_reg - 1'b1;
        end
        if (stat.div_done && !cmd.div_sel && !cmd.div_rep && !cmd.div_start)
            mean_reg <= MW'(dq_reg);
        sig_reg <= SW'(qres_reg);
        if (cmd.cur)
        begin
            if (cur_sum > 29'sd67108863)
                cur_reg <= 28'sd67108863;
            else if (cur_sum < -29'sd67108864)
                cur_reg <= -28'sd67108864;
            else
                cur_reg <= 28'(cur_sum);
        end
        if (cmd.div_rep && stat.div_done && !cmd.div_start)
            prod_reg <= (vw_reg == 6'd0) ? 42'sd128
                      : signed'(42'({1'b0, slope_reg} * 25'(dq_reg)) + 42'd128);
        if (cmd.pow)
            prod_reg <= 42'(cur_reg * signed'({1'b0, volts_reg}));
        if (cmd.out_load)
        begin
            o_cur_reg <= cur_reg[26:0];
            o_pow_reg <= prod_reg[35:0];
            o_abv_reg <= cur_reg > signed'({8'd0, thresh_reg});
            o_vw_reg <= vw_reg;
        end
    end

    assign stat.warm = warm_cnt_reg < warmup_reg;
    // within one of expected, written as expected <= n + 1 so that small settings hold
    assign stat.valid = win_reg != '0 && win_reg <= CW'(wscm_pkg::BUFFER_DEPTH)
                        && CW'(expected_reg) <= win_reg + 1'b1
                        && win_reg <= CW'(expected_reg) + 1'b1;
    assign stat.walk_done = !rd_ok_reg && ptr_reg >= win_reg;
    assign stat.div_done = !dbusy_reg;
    assign stat.sqrt_done = !qbusy_reg;
    assign stat.report = tick_reg >= ticks_reg;
    assign stat.out_busy = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign current_ua = o_cur_reg;
    assign power_uw = o_pow_reg;
    assign above_threshold = o_abv_reg;
    assign windows_used = o_vw_reg;
endmodule

// ===== sv/wscm_ctrl.sv =====
// controller state machine of the windowed sigma current meter
// sequences the datapath through commands; uses wscm_pkg
module wscm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            command,
    output logic            in_ready,
    input  wscm_pkg::stat_t stat,
    output wscm_pkg::cmd_t  cmd
);
    wscm_pkg::state_t state_reg, state_next;
    logic first_reg, first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wscm_pkg::ST_IDLE;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        first_next = 1'b0;
        case (state_reg)
            wscm_pkg::ST_IDLE:
                if (in_fire && command && !stat.warm)
                begin
                    state_next = stat.valid ? wscm_pkg::ST_SUM : wscm_pkg::ST_ACC;
                    first_next = 1'b1;
                end
            wscm_pkg::ST_SUM:
                if (!first_reg && stat.walk_done)
                begin
                    state_next = wscm_pkg::ST_MEAN;
                    first_next = 1'b1;
                end
            wscm_pkg::ST_MEAN:
                if (!first_reg && stat.div_done)
                begin
                    state_next = wscm_pkg::ST_SQ;
                    first_next = 1'b1;
                end
            wscm_pkg::ST_SQ:
                if (!first_reg && stat.walk_done)
                begin
                    state_next = wscm_pkg::ST_VAR;
                    first_next = 1'b1;
                end
            wscm_pkg::ST_VAR:
                if (!first_reg && stat.div_done)
                begin
                    state_next = wscm_pkg::ST_SQRT;
                    first_next = 1'b1;
                end
            wscm_pkg::ST_SQRT:
                if (!first_reg && stat.sqrt_done)
                begin
                    state_next = wscm_pkg::ST_ACC;
                    first_next = 1'b1;
                end
            wscm_pkg::ST_ACC:
                if (!first_reg)
                begin
                    state_next = stat.report ? wscm_pkg::ST_REPORT : wscm_pkg::ST_IDLE;
                    first_next = stat.report;
                end
            wscm_pkg::ST_REPORT:
                if (!first_reg && stat.div_done)
                    state_next = wscm_pkg::ST_CUR;
            wscm_pkg::ST_CUR:
                state_next = wscm_pkg::ST_POW;
            wscm_pkg::ST_POW:
                state_next = wscm_pkg::ST_OUT;
            wscm_pkg::ST_OUT:
                if (!stat.out_busy)
                    state_next = wscm_pkg::ST_IDLE;
            default:
                state_next = wscm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            wscm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.store = in_fire && !command;
                cmd.warm_tick = in_fire && command && stat.warm;
                cmd.clr_win = in_fire && command && stat.warm;
                cmd.sum_start = in_fire && command;
            end
            wscm_pkg::ST_SUM:
                cmd.sum_step = 1'b1;
            wscm_pkg::ST_MEAN:
                cmd.div_start = first_reg;
            wscm_pkg::ST_SQ:
            begin
                cmd.sq_start = first_reg;
                cmd.sq_step = !first_reg;
            end
            wscm_pkg::ST_VAR:
            begin
                cmd.div_start = first_reg;
                cmd.div_sel = 1'b1;
            end
            wscm_pkg::ST_SQRT:
            begin
                cmd.sqrt_start = first_reg;
                cmd.div_sel = 1'b1;
            end
            wscm_pkg::ST_ACC:
                if (first_reg)
                begin
                    cmd.acc = stat.valid;
                    cmd.clr_win = 1'b1;
                    cmd.tick_cnt = 1'b1;
                    cmd.div_sel = 1'b1;
                end
            wscm_pkg::ST_REPORT:
            begin
                cmd.div_rep = 1'b1;
                cmd.div_start = first_reg;
            end
            wscm_pkg::ST_CUR:
            begin
                cmd.cur = 1'b1;
                cmd.div_sel = 1'b1;
            end
            wscm_pkg::ST_POW:
            begin
                cmd.pow = 1'b1;
                cmd.div_sel = 1'b1;
            end
            wscm_pkg::ST_OUT:
            begin
                cmd.div_sel = 1'b1;
                cmd.out_load = !stat.out_busy;
                cmd.clr_tot = !stat.out_busy;
            end
            default: ;
        endcase
    end
endmodule

// ===== sv/windowed_sigma_current_meter.sv =====
// top level of the windowed sigma current meter
// a sample transfer is stored while idle; a tick with a valid window runs two walks of
// the sample memory, a 45-step divider twice and a 23-step square root; a report tick
// runs the divider again; a tick with no valid window skips these; one item at a time
// reset (rst_n, asynchronous) restores default config and clears all counts and totals
// depends on wscm_pkg, wscm_ctrl, wscm_datapath
module windowed_sigma_current_meter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] sample
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [26:0] current_ua, [62:27] power_uw,
                                   // [63] above_threshold, [69:64] windows_used
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    wscm_pkg::cmd_t  cmd;
    wscm_pkg::stat_t stat;
    logic [26:0] cur;
    logic [35:0] pw;
    logic        abv;
    logic [5:0]  vw;

    assign cfg_ready = 1'b1;

    wscm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_tvalid && s_tready), .command(s_tuser),
        .in_ready(s_tready), .stat(stat), .cmd(cmd)
    );

    wscm_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .sample(s_tdata[wscm_pkg::ADC_BITS-1:0]),
        .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .current_ua(cur), .power_uw(pw), .above_threshold(abv), .windows_used(vw)
    );

    assign m_tdata = {2'b00, vw, abv, pw, cur};
endmodule

// ===== sv/wscm_checker.sv =====
// port-level checker for the windowed sigma current meter, bound to the top level
// depends on windowed_sigma_current_meter ports only
module wscm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[71:70] == 2'b00)
        else $error("padding bits set");
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[26] |-> !m_tdata[63])
        else $error("negative current flagged above threshold");
    // a report never starts right after an input transfer
    a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result raised right after input transfer");
    a_reset: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid out of reset");
endmodule

bind windowed_sigma_current_meter wscm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== verif/windowed_sigma_current_meter_tb.sv =====
// testbench for the windowed sigma current meter: streams samples and ticks, predicts reports
// with a fixed-point sigma model and checks every report transfer; depends on wscm_pkg
module windowed_sigma_current_meter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       tick;
        logic [9:0] sample;
    } meter_item_t;

    // highest field first, so the struct lines up with m_tdata[69:0]
    typedef struct packed {
        logic [5:0]         windows_used;
        logic               above_threshold;
        logic signed [35:0] power_uw;
        logic signed [26:0] current_ua;
    } meter_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    windowed_sigma_current_meter u_dut (.*);

    always #4 clk = ~clk;

    // predictor state
    int unsigned       warmup_ticks, ticks_per_report, expected_samples, slope, threshold, volts;
    longint            intercept;
    int unsigned       window_buf[wscm_pkg::BUFFER_DEPTH];
    int unsigned       window_count, warmup_count, tick_count, valid_windows;
    longint unsigned   sigma_total;

    meter_item_t   pending_items[$];
    meter_report_t expected_reports[$];
    int            error_count = 0;
    bit            calm = 1'b0;   // no idling while set

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned window_sigma(input int unsigned n);
        longint unsigned sum = 0, sq = 0;
        longint          mean_q8, d;
        for (int i = 0; i < n; i++) sum += window_buf[i];
        mean_q8 = longint'((sum * 256 + n / 2) / n);
        for (int i = 0; i < n; i++)
        begin
            d = longint'(window_buf[i]) * 256 - mean_q8;
            sq += longint'(d * d);
        end
        return int_sqrt(sq / n);
    endfunction

    task automatic predict_reset();
        warmup_ticks = 5; ticks_per_report = 60; expected_samples = 250;
        slope = 66000; intercept = -7000; threshold = 36000; volts = 230;
        window_count = 0; warmup_count = 0; tick_count = 0;
        sigma_total = 0; valid_windows = 0;
    endtask

    task automatic predict_meter(input meter_item_t it);
        longint          diff, cur, pw;
        longint unsigned mean_sigma;
        meter_report_t   r;
        if (!it.tick)
        begin
            if (window_count < wscm_pkg::BUFFER_DEPTH)
            begin
                window_buf[window_count] = it.sample;
                window_count++;
            end
            else
                window_count = wscm_pkg::BUFFER_DEPTH + 1;
            return;
        end
        if (warmup_count < warmup_ticks)
        begin
            warmup_count++;
            window_count = 0;
            return;
        end
        diff = longint'(window_count) - longint'(expected_samples);
        if (window_count != 0 && window_count <= wscm_pkg::BUFFER_DEPTH
            && diff >= -1 && diff <= 1)
        begin
            sigma_total += window_sigma(window_count);
            if (sigma_total > 64'hFFFFFF) sigma_total = 64'hFFFFFF;
            if (valid_windows < 63) valid_windows++;
        end
        window_count = 0;
        if (tick_count < 63) tick_count++;
        if (tick_count < ticks_per_report) return;
        mean_sigma = 0;
        if (valid_windows != 0)
            mean_sigma = (sigma_total + valid_windows / 2) / valid_windows;
        cur = longint'((longint'(slope) * mean_sigma + 128) >> 8) + intercept;
        if (cur > 67108863) cur = 67108863;
        if (cur < -67108864) cur = -67108864;
        pw = cur * longint'(volts);
        r.current_ua = cur[26:0];
        r.power_uw = pw[35:0];
        r.above_threshold = cur > longint'(threshold);
        r.windows_used = valid_windows[5:0];
        expected_reports.push_back(r);
        tick_count = 0; sigma_total = 0; valid_windows = 0;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 27))
                begin
                    meter_item_t it;
                    it = pending_items.pop_front();
                    predict_meter(it);
                    s_tvalid <= 1'b1;
                    s_tuser  <= it.tick;
                    s_tdata  <= {6'd0, it.sample};
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= calm || $urandom_range(99) >= 27;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            meter_report_t got, want;
            got = m_tdata[69:0];
            if (expected_reports.size() == 0)
                report_mismatch("report transfer with none expected");
            else
            begin
                want = expected_reports.pop_front();
                if (got.current_ua !== want.current_ua)
                    report_mismatch($sformatf("current_ua %0d exp %0d",
                        got.current_ua, want.current_ua));
                if (got.power_uw !== want.power_uw)
                    report_mismatch($sformatf("power_uw %0d exp %0d",
                        got.power_uw, want.power_uw));
                if (got.above_threshold !== want.above_threshold)
                    report_mismatch("above_threshold differs");
                if (got.windows_used !== want.windows_used)
                    report_mismatch($sformatf("windows_used %0d exp %0d",
                        got.windows_used, want.windows_used));
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            wscm_pkg::CFG_WARMUP:    warmup_ticks = val & 7;
            wscm_pkg::CFG_TICKS:     ticks_per_report = val & 63;
            wscm_pkg::CFG_EXPECTED:  expected_samples = val & 255;
            wscm_pkg::CFG_SLOPE:     slope = val & 32'h1FFFF;
            wscm_pkg::CFG_INTERCEPT: intercept = longint'(signed'(21'(val)));
            wscm_pkg::CFG_THRESHOLD: threshold = val & 32'hFFFFF;
            wscm_pkg::CFG_VOLTS:     volts = val & 511;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_reports.size() != 0 || s_tvalid)
            @(posedge clk);
        // a tick with no report may still be computing
        repeat (700) @(posedge clk);
    endtask

    task automatic queue_window(input int n, input int mode);
        meter_item_t it;
        int unsigned c = $urandom_range(1023);
        for (int i = 0; i < n; i++)
        begin
            it.tick = 1'b0;
            case (mode)
                0: it.sample = $urandom_range(1023);
                1: it.sample = c[9:0];
                2: it.sample = $urandom_range(1) ? 10'h3FF : 10'h000;
                default: it.sample = c[9:0] + $urandom_range(8) - 4;
            endcase
            pending_items.push_back(it);
        end
        it.tick = 1'b1;
        it.sample = $urandom_range(1023);
        pending_items.push_back(it);
    endtask

    initial
    begin
        int n;
        int unsigned exp_n;
        predict_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: short windows, every register, extremes
        write_reg(wscm_pkg::CFG_WARMUP, 1);
        write_reg(wscm_pkg::CFG_TICKS, 2);
        write_reg(wscm_pkg::CFG_EXPECTED, 3);
        write_reg(wscm_pkg::CFG_SLOPE, 131071);
        write_reg(wscm_pkg::CFG_INTERCEPT, 32'h100000);
        write_reg(wscm_pkg::CFG_THRESHOLD, 1048575);
        write_reg(wscm_pkg::CFG_VOLTS, 511);
        queue_window(3, 2);      // warm-up, dropped
        queue_window(3, 2);      // full swing 0/1023
        queue_window(0, 0);      // empty window
        queue_window(4, 1);      // constant
        queue_window(2, 0);
        drain();
        write_reg(wscm_pkg::CFG_INTERCEPT, 1048575);
        write_reg(wscm_pkg::CFG_TICKS, 0);
        write_reg(wscm_pkg::CFG_WARMUP, 0);
        write_reg(wscm_pkg::CFG_THRESHOLD, 0);
        write_reg(wscm_pkg::CFG_VOLTS, 0);
        write_reg(wscm_pkg::CFG_SLOPE, 0);
        queue_window(5, 0);      // invalid: no window, current = intercept
        drain();
        // overfull buffer, then a 255-sample window
        write_reg(wscm_pkg::CFG_EXPECTED, 254);
        write_reg(wscm_pkg::CFG_TICKS, 1);
        write_reg(wscm_pkg::CFG_VOLTS, 511);
        write_reg(wscm_pkg::CFG_SLOPE, 131071);
        write_reg(wscm_pkg::CFG_INTERCEPT, 0);
        queue_window(258, 2);
        queue_window(255, 0);
        drain();

        // random phases; mostly small windows
        calm = 1'b1;
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 2) calm = 1'b0;
            write_reg(wscm_pkg::CFG_WARMUP, ph == 7 ? 7 : $urandom_range(2));
            write_reg(wscm_pkg::CFG_TICKS, ph == 6 ? 63 : $urandom_range(1, 4));
            exp_n = ph == 6 ? 2 : $urandom_range(2, 12);
            write_reg(wscm_pkg::CFG_EXPECTED, exp_n);
            write_reg(wscm_pkg::CFG_SLOPE, $urandom_range(131071));
            write_reg(wscm_pkg::CFG_INTERCEPT, $urandom);
            write_reg(wscm_pkg::CFG_THRESHOLD, $urandom_range(1048575));
            write_reg(wscm_pkg::CFG_VOLTS, $urandom_range(511));
            for (int w = 0; w < (ph == 6 ? 66 : (ph == 7 ? 10 : 6)); w++)
            begin
                if ($urandom_range(9) < 8)
                    n = int'(exp_n) + $urandom_range(2) - 1;
                else
                    n = $urandom_range(exp_n + 4);
                queue_window(n, $urandom_range(3));
            end
            drain();
        end
        if (error_count == 0)
            $display("windowed_sigma_current_meter_tb OK");
        else
            $display("windowed_sigma_current_meter_tb NOT OK");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("windowed_sigma_current_meter_tb NOT OK");
        $finish;
    end
endmodule
